// ===== design/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg
// Types, pipeline constants and helper functions used by the particle
// state evaluator top module.
// ----------------------------------------------------------------------------
package pse_pkg;

  // total register stages from input to output register
  localparam int Latency  = 19;
  // quotient widths of the size and colour interpolation dividers
  localparam int SizeQW   = 16;
  localparam int ColorQW  = 8;
  // divisor width (two times a Q8.8 time)
  localparam int DenW     = 17;
  localparam int SizeNumW = DenW + SizeQW;
  localparam int ColorNumW = DenW + ColorQW;

  typedef struct packed {
    logic        is_quad;
    logic [31:0] end_color;
    logic [31:0] start_color;
    logic [63:0] size_range;
    logic [31:0] spin;
    logic [31:0] constant_acceleration;
    logic [31:0] start_velocity;
    logic [31:0] start_position;
    logic [15:0] fade_out_time;
    logic [15:0] fade_in_time;
    logic [15:0] life_time;
    logic [15:0] age;
  } pse_in_t;

  typedef struct packed {
    logic        shape_quad;
    logic [31:0] color_now;
    logic [31:0] size_now;
    logic [15:0] angle_now;
    logic [31:0] position_now;
    logic        alive;
  } pse_out_t;

  // per-item info carried alongside the dividers
  typedef struct packed {
    logic                 alive;
    logic                 shape_quad;
    logic                 l_zero;
    logic [1:0][15:0]     size_a;
    logic [1:0]           size_neg;
    logic [2:0][7:0]      col_a;
    logic [2:0]           col_neg;
  } pse_side_t;

  // alpha channel info needed for the fade stage
  typedef struct packed {
    logic        l_zero;
    logic [7:0]  a;
    logic        neg;
    logic [15:0] num;
    logic [15:0] den;
  } pse_alpha_t;

  // dividend of a rounded lerp: 2*|b-a|*t + L, minus one when b < a
  function automatic logic [SizeNumW-1:0] lerp_num(input logic [15:0] a, input logic [15:0] b,
                                                   input logic [15:0] t, input logic [15:0] l);
    logic [15:0] mag;
    logic [31:0] prod;
    mag  = (b >= a) ? 16'(b - a) : 16'(a - b);
    prod = 32'(mag) * 32'(t);
    return {prod, 1'b0} + SizeNumW'(l) - SizeNumW'(b < a);
  endfunction

  // start value moved toward the end value by the quotient
  function automatic logic [15:0] lerp_end(input logic [15:0] a, input logic [15:0] q,
                                           input logic neg);
    return neg ? 16'(a - q) : 16'(a + q);
  endfunction

endpackage

// ===== design/pse_stream_if.sv =====
// ----------------------------------------------------------------------------
// pse_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface pse_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/pse_divider.sv =====
// ----------------------------------------------------------------------------
// pse_divider
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees that the quotient fits in QW bits.
// ----------------------------------------------------------------------------
module pse_divider #(
  parameter int QW = 8,
  parameter int DW = 17
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DW+QW-1:0] num,
  input  logic [DW-1:0]    den,
  output logic [QW-1:0]    quot
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    // stage input: operands for the first step, previous stage otherwise
    if (i == 0) begin : g_first
      assign rem_in = num[DW+QW-1:QW];
      assign low_in = num[QW-1:0];
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign low_in = low_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
    end

    // shift in one dividend bit and try the subtract
    always_comb begin
      trial   = {rem_in, low_in[QW-1]};
      ge      = (trial >= {1'b0, den_in});
      rem_nxt = ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        low_r[i] <= low_in << 1;
        den_r[i] <= den_in;
        q_r[i]   <= {q_in[QW-2:0], ge};
      end
    end
  end

  assign quot = q_r[QW-1];

endmodule

// ===== design/pse_delay.sv =====
// ----------------------------------------------------------------------------
// pse_delay
// Enabled shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module pse_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe_r [DEPTH];

  // shift on every pipeline advance
  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_r[i] <= pipe_r[i-1];
      end
    end
  end

  assign q = pipe_r[DEPTH-1];

endmodule

// ===== design/pse_kinematics.sv =====
// ----------------------------------------------------------------------------
// pse_kinematics
// Three-stage position and rotation unit: p0 + v*t + a*t*t/2 per axis with
// rounding and saturation, and start angle plus rounded rate*t.
// ----------------------------------------------------------------------------
module pse_kinematics (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] age,
  input  logic [31:0] start_position,
  input  logic [31:0] start_velocity,
  input  logic [31:0] constant_acceleration,
  input  logic [31:0] spin,
  output logic [31:0] position_now,
  output logic [15:0] angle_now
);

  logic signed [16:0] t_s;
  logic [31:0]        tt_r;
  logic signed [32:0] rt_r;
  logic [15:0]        ang0_r;
  logic [15:0]        ang2_r;
  logic [15:0]        ang3_r;
  logic signed [32:0] rt_rnd;

  assign t_s = signed'({1'b0, age});

  // rotation: stage 1 product, stage 2 round and add, stage 3 align
  assign rt_rnd = rt_r + 33'sd128;

  always_ff @(posedge clk) begin
    if (en) begin
      tt_r   <= 32'(age) * 32'(age);
      rt_r   <= 33'(signed'(spin[31:16])) * 33'(t_s);
      ang0_r <= spin[15:0];
      ang2_r <= 16'(ang0_r + rt_rnd[23:8]);
      ang3_r <= ang2_r;
    end
  end

  assign angle_now = ang3_r;

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    logic signed [15:0] p1_r;
    logic signed [15:0] a1_r;
    logic signed [32:0] vt1_r;
    logic signed [15:0] p2_r;
    logic signed [32:0] vt2_r;
    logic signed [48:0] att2_r;
    logic signed [49:0] sum;
    logic signed [49:0] sum_rnd;
    logic signed [32:0] res;
    logic [15:0]        sat;
    logic [15:0]        pos3_r;

    // final sum has 21 fraction bits, round half up back to Q12.4
    always_comb begin
      sum     = (50'(p2_r) <<< 17) + (50'(vt2_r) <<< 9) + 50'(att2_r);
      sum_rnd = sum + 50'sd65536;
      res     = sum_rnd[49:17];
      if (res > 33'sd32767) begin
        sat = 16'h7fff;
      end else if (res < -33'sd32768) begin
        sat = 16'h8000;
      end else begin
        sat = res[15:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p1_r   <= signed'(start_position[16*ax +: 16]);
        a1_r   <= signed'(constant_acceleration[16*ax +: 16]);
        vt1_r  <= 33'(signed'(start_velocity[16*ax +: 16])) * 33'(t_s);
        p2_r   <= p1_r;
        vt2_r  <= vt1_r;
        att2_r <= 49'(a1_r) * 49'(signed'({1'b0, tt_r}));
        pos3_r <= sat;
      end
    end

    assign position_now[16*ax +: 16] = pos3_r;
  end

endmodule

// ===== design/particle_state_evaluator.sv =====
// ----------------------------------------------------------------------------
// particle_state_evaluator
// Evaluates position, rotation, size and faded colour of one particle at a
// given age, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one particle per transaction (age, lifetime, fade times,
//   motion, size range, colours, shape); out_if returns one evaluated
//   particle per input transaction, in order.
//   One particle is taken every cycle while out_if is not stalled; the
//   depth is set by the alpha path (8 lerp steps, a fade multiply, 8
//   fade steps), which is longer than the size dividers (16 restoring
//   steps).
//   A dead particle (age above lifetime) gives alive = 0 and all other
//   fields zero.
//   When out_if is stalled with a result waiting, the whole pipeline holds;
//   in_if.ready is high while the output stage is empty or being taken and
//   low while a result waits, so no bubble is filled during a stall.
//   Reset (rst_n low, synchronous) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module particle_state_evaluator
  import pse_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  pse_stream_if.sink   in_if,
  pse_stream_if.source out_if
);

  logic                 en;
  logic [Latency-1:0]   valid_r;
  pse_in_t              din;

  // stage 1 registers
  pse_side_t            side_nxt;
  pse_side_t            side_s1_r;
  pse_alpha_t           alpha_nxt;
  pse_alpha_t           alpha_s1_r;
  logic [SizeNumW-1:0]  size_num_r [2];
  logic [ColorNumW-1:0] col_num_r  [4];
  logic [DenW-1:0]      den_s1_r;
  logic [SizeNumW-1:0]  col_num_full [4];

  // divider results and aligned data
  logic [SizeQW-1:0]    size_q  [2];
  logic [ColorQW-1:0]   col_q   [4];
  logic [31:0]          size_q18;
  logic [23:0]          col_q18;
  pse_side_t            side_s18;
  pse_alpha_t           alpha_s9;
  logic [31:0]          pos_s3;
  logic [15:0]          ang_s3;
  logic [31:0]          pos_s18;
  logic [15:0]          ang_s18;

  // fade stage
  logic [7:0]           alpha_c;
  logic [ColorNumW-1:0] fade_num_r;
  logic [DenW-1:0]      fade_den_r;
  logic [ColorQW-1:0]   fade_q;

  pse_out_t             out_nxt;
  pse_out_t             out_r;

  assign din = in_if.payload;

  // pipeline advances when the output stage is empty or being taken
  assign en           = !valid_r[Latency-1] || out_if.ready;
  assign in_if.ready  = en;
  assign out_if.valid = valid_r[Latency-1];
  assign out_if.payload = out_r;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[Latency-2:0], in_if.valid};
    end
  end

  // stage 1: lerp dividends, fade selection, side info
  always_comb begin
    side_nxt.alive      = (din.age <= din.life_time);
    side_nxt.shape_quad = din.is_quad;
    side_nxt.l_zero     = (din.life_time == '0);
    for (int k = 0; k < 2; k++) begin
      side_nxt.size_a[k]   = din.size_range[16*k +: 16];
      side_nxt.size_neg[k] = (din.size_range[16*k+32 +: 16] < din.size_range[16*k +: 16]);
    end
    for (int k = 0; k < 3; k++) begin
      side_nxt.col_a[k]   = din.start_color[8*k +: 8];
      side_nxt.col_neg[k] = (din.end_color[8*k +: 8] < din.start_color[8*k +: 8]);
    end
    for (int k = 0; k < 4; k++) begin
      col_num_full[k] = lerp_num(16'(din.start_color[8*k +: 8]), 16'(din.end_color[8*k +: 8]),
                                 din.age, din.life_time);
    end
    alpha_nxt.l_zero = (din.life_time == '0);
    alpha_nxt.a      = din.start_color[31:24];
    alpha_nxt.neg    = (din.end_color[31:24] < din.start_color[31:24]);
    // fade-out overrides fade-in
    alpha_nxt.num = 16'd1;
    alpha_nxt.den = 16'd1;
    if (din.age < din.fade_in_time) begin
      alpha_nxt.num = din.age;
      alpha_nxt.den = din.fade_in_time;
    end
    if ((17'(din.age) + 17'(din.fade_out_time)) > 17'(din.life_time)) begin
      alpha_nxt.num = 16'(din.life_time - din.age);
      alpha_nxt.den = din.fade_out_time;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_s1_r  <= side_nxt;
      alpha_s1_r <= alpha_nxt;
      den_s1_r   <= {din.life_time, 1'b0};
      for (int k = 0; k < 2; k++) begin
        size_num_r[k] <= lerp_num(din.size_range[16*k +: 16], din.size_range[16*k+32 +: 16],
                                  din.age, din.life_time);
      end
      for (int k = 0; k < 4; k++) begin
        col_num_r[k] <= col_num_full[k][ColorNumW-1:0];
      end
    end
  end

  // size dividers, stages 2 to 17
  for (genvar k = 0; k < 2; k++) begin : g_size_div
    pse_divider #(.QW(SizeQW), .DW(DenW)) u_div (
      .clk  (clk),
      .en   (en),
      .num  (size_num_r[k]),
      .den  (den_s1_r),
      .quot (size_q[k])
    );
  end

  // colour dividers, stages 2 to 9
  for (genvar k = 0; k < 4; k++) begin : g_col_div
    pse_divider #(.QW(ColorQW), .DW(DenW)) u_div (
      .clk  (clk),
      .en   (en),
      .num  (col_num_r[k]),
      .den  (den_s1_r),
      .quot (col_q[k])
    );
  end

  pse_delay #(.W(32), .DEPTH(1)) u_size_dly (
    .clk (clk), .en (en), .d ({size_q[1], size_q[0]}), .q (size_q18)
  );

  pse_delay #(.W(24), .DEPTH(9)) u_col_dly (
    .clk (clk), .en (en), .d ({col_q[2], col_q[1], col_q[0]}), .q (col_q18)
  );

  pse_delay #(.W($bits(pse_side_t)), .DEPTH(17)) u_side_dly (
    .clk (clk), .en (en), .d (side_s1_r), .q (side_s18)
  );

  pse_delay #(.W($bits(pse_alpha_t)), .DEPTH(8)) u_alpha_dly (
    .clk (clk), .en (en), .d (alpha_s1_r), .q (alpha_s9)
  );

  // stage 10: interpolated alpha times fade numerator
  always_comb begin
    if (alpha_s9.l_zero) begin
      alpha_c = alpha_s9.a;
    end else if (alpha_s9.neg) begin
      alpha_c = 8'(alpha_s9.a - col_q[3]);
    end else begin
      alpha_c = 8'(alpha_s9.a + col_q[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fade_num_r <= {1'b0, 24'(alpha_c) * 24'(alpha_s9.num)} << 1;
      fade_den_r <= {alpha_s9.den, 1'b0};
    end
  end

  // fade divider, stages 11 to 18
  pse_divider #(.QW(ColorQW), .DW(DenW)) u_fade_div (
    .clk  (clk),
    .en   (en),
    .num  (fade_num_r + ColorNumW'(fade_den_r[DenW-1:1])),
    .den  (fade_den_r),
    .quot (fade_q)
  );

  // motion, stages 1 to 3, aligned to stage 18
  pse_kinematics u_kin (
    .clk                   (clk),
    .en                    (en),
    .age                   (din.age),
    .start_position        (din.start_position),
    .start_velocity        (din.start_velocity),
    .constant_acceleration (din.constant_acceleration),
    .spin                  (din.spin),
    .position_now          (pos_s3),
    .angle_now             (ang_s3)
  );

  pse_delay #(.W(48), .DEPTH(15)) u_kin_dly (
    .clk (clk), .en (en), .d ({ang_s3, pos_s3}), .q ({ang_s18, pos_s18})
  );

  // stage 19: assemble result, zero everything for a dead particle
  always_comb begin
    out_nxt = '0;
    if (side_s18.alive) begin
      out_nxt.alive        = 1'b1;
      out_nxt.shape_quad   = side_s18.shape_quad;
      out_nxt.position_now = pos_s18;
      out_nxt.angle_now    = ang_s18;
      for (int k = 0; k < 2; k++) begin
        out_nxt.size_now[16*k +: 16] = side_s18.l_zero ? side_s18.size_a[k] :
            lerp_end(side_s18.size_a[k], size_q18[16*k +: 16], side_s18.size_neg[k]);
      end
      for (int k = 0; k < 3; k++) begin
        out_nxt.color_now[8*k +: 8] = side_s18.l_zero ? side_s18.col_a[k] :
            (side_s18.col_neg[k] ? 8'(side_s18.col_a[k] - col_q18[8*k +: 8]) :
                                   8'(side_s18.col_a[k] + col_q18[8*k +: 8]));
      end
      out_nxt.color_now[31:24] = fade_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  // a dead particle reports nothing but its death
  a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_r.alive |-> out_r.position_now == '0 && out_r.size_now == '0 &&
      out_r.color_now == '0 && out_r.angle_now == '0 && !out_r.shape_quad)
    else $error("dead particle with nonzero fields");

  // a stalled pipeline keeps every valid bit in place
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(valid_r))
    else $error("valid bits moved during stall");

  // an accepted transaction enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> valid_r[0])
    else $error("accepted transaction lost at entry");

  // the output stage drains when the receiver takes it and nothing follows
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.ready && !valid_r[Latency-2] |=> !out_if.valid)
    else $error("result repeated after transaction");

endmodule
